/* hdl/mlcr_pkg.sv */
// Shared constants and types for the midpoint line color rasterizer.
package mlcr_pkg;

    localparam int COORD_BITS      = 12;
    localparam int COLOR_BITS      = 8;
    localparam int COLOR_FRAC_BITS = 16;
    localparam int NUM_CHAN        = 3;
    localparam int CHAN_BITS       = 2;

    // Unsigned 8.F color accumulator and signed 8.F color step.
    localparam int ACC_BITS = COLOR_BITS + COLOR_FRAC_BITS;
    localparam int INC_BITS = ACC_BITS + 1;

    // Doubled midpoint decision spans about four major lengths.
    localparam int DEC_BITS = COORD_BITS + 3;

    // The divider retires one quotient bit per cycle.
    localparam int DIV_STEPS    = ACC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

    // Request codes.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // Request to the color step divider.
    typedef struct packed {
        logic                  start;
        logic [ACC_BITS-1:0]   dividend;
        logic [COORD_BITS-1:0] divisor;
    } div_req_t;

    // Response from the color step divider.
    typedef struct packed {
        logic                done;
        logic [ACC_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

/* hdl/mlcr_item_if.sv */
// Valid/ready channel carrying one line request (load or step).
interface mlcr_item_if;
    import mlcr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] red_start;
    logic [COLOR_BITS-1:0] green_start;
    logic [COLOR_BITS-1:0] blue_start;
    logic [COLOR_BITS-1:0] red_end;
    logic [COLOR_BITS-1:0] green_end;
    logic [COLOR_BITS-1:0] blue_end;

    modport source (
        output valid, mode, x_start, y_start, x_end, y_end,
               red_start, green_start, blue_start, red_end, green_end, blue_end,
        input  ready
    );

    modport sink (
        input  valid, mode, x_start, y_start, x_end, y_end,
               red_start, green_start, blue_start, red_end, green_end, blue_end,
        output ready
    );
endinterface

/* hdl/mlcr_pixel_if.sv */
// Valid/ready channel carrying one rasterized pixel.
interface mlcr_pixel_if;
    import mlcr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic                  last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, red, green, blue, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, red, green, blue, last_pixel,
        output ready
    );
endinterface

/* hdl/midpoint_line_color_raster.sv */
// Midpoint line rasterizer with linear RGB interpolation, top level.
//
// Usage: requests arrive on line_in, pixels leave on pixel_out; both are
// valid/ready channels and a transfer happens on a clock edge with both high.
// A load request (mode 0) latches a line. Its geometry is set up in the cycle
// of the transfer; the three color steps are then divided one after another
// by a shared bit-serial divider, so a load of a line with nonzero length
// keeps line_in.ready low until all three divisions are done. A point line
// needs no division and the block is ready again in the next cycle.
// Each step request (mode 1) with an active line produces one pixel, shown on
// pixel_out in the cycle after the transfer, and step requests can be taken one
// per cycle while the receiver keeps pixel_out.ready high. The final pixel of
// a line has last_pixel set; a step with no active line produces nothing. A load
// replaces any line still in progress. The pixel sits in an output register:
// while it waits, line_in.ready stays high only if pixel_out.ready is high, so a
// stalled receiver holds the block. Reset clears the active line and the output
// register; loads are needed before pixels come out.
module midpoint_line_color_raster (
    input  logic         clk,
    input  logic         rst_n,
    mlcr_item_if.sink    line_in,
    mlcr_pixel_if.source pixel_out
);
    import mlcr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_START = 3'b010,
        ST_WAIT  = 3'b100
    } state_t;

    state_t                      state_reg;
    logic                        active_reg;
    logic [COORD_BITS-1:0]       cur_x_reg;
    logic [COORD_BITS-1:0]       cur_y_reg;
    logic [COORD_BITS-1:0]       steps_left_reg;
    logic signed [DEC_BITS-1:0]  decision_reg;
    logic                        major_is_x_reg;
    logic                        minor_used_reg;
    logic                        major_step_neg_reg;
    logic                        minor_step_neg_reg;
    logic [COORD_BITS-1:0]       major_len_reg;
    logic [COORD_BITS-1:0]       minor_len_reg;
    logic [CHAN_BITS-1:0]        chan_reg;
    logic [ACC_BITS-1:0]         color_acc_reg [NUM_CHAN];
    logic signed [INC_BITS-1:0]  color_inc_reg [NUM_CHAN];
    logic [COLOR_BITS-1:0]       diff_mag_reg  [NUM_CHAN];
    logic                        diff_neg_reg  [NUM_CHAN];

    logic                        out_valid_reg;
    logic [COORD_BITS-1:0]       out_x_reg;
    logic [COORD_BITS-1:0]       out_y_reg;
    logic [COLOR_BITS-1:0]       out_color_reg [NUM_CHAN];
    logic                        out_last_reg;

    logic                        accept;
    logic                        do_load;
    logic                        do_step;

    logic [COORD_BITS:0]         dx;
    logic [COORD_BITS:0]         dy;
    logic [COORD_BITS-1:0]       adx;
    logic [COORD_BITS-1:0]       ady;
    logic                        load_major_x;
    logic [COORD_BITS-1:0]       load_major;
    logic [COORD_BITS-1:0]       load_minor;
    logic signed [DEC_BITS-1:0]  load_decision;
    logic [COLOR_BITS-1:0]       col_start [NUM_CHAN];
    logic [COLOR_BITS-1:0]       col_end   [NUM_CHAN];

    logic [COORD_BITS-1:0]       steps_next;
    logic                        last;
    logic                        minor_move;
    logic [COORD_BITS-1:0]       len_diff;
    logic signed [DEC_BITS-1:0]  decision_next;
    logic                        moving;
    logic [COORD_BITS-1:0]       x_next;
    logic [COORD_BITS-1:0]       y_next;

    mlcr_pkg::div_req_t          div_req;
    mlcr_pkg::div_rsp_t          div_rsp;
    logic [INC_BITS-1:0]         quo_ext;
    logic signed [INC_BITS-1:0]  inc_signed;

    // Handshake on the request side.
    assign line_in.ready = (state_reg == ST_IDLE) && (!out_valid_reg || pixel_out.ready);
    assign accept        = line_in.valid && line_in.ready;
    assign do_load       = accept && (line_in.mode == MODE_LOAD);
    assign do_step       = accept && (line_in.mode == MODE_STEP) && active_reg;

    // Line setup: axis lengths, directions and the doubled midpoint start value.
    always_comb
    begin
        dx  = {1'b0, line_in.x_end} - {1'b0, line_in.x_start};
        dy  = {1'b0, line_in.y_end} - {1'b0, line_in.y_start};
        adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        load_major_x  = adx >= ady;
        load_major    = load_major_x ? adx : ady;
        load_minor    = load_major_x ? ady : adx;
        load_decision = $signed({3'b000, load_major}) - $signed({2'b00, load_minor, 1'b0});
        col_start[0]  = line_in.red_start;
        col_start[1]  = line_in.green_start;
        col_start[2]  = line_in.blue_start;
        col_end[0]    = line_in.red_end;
        col_end[1]    = line_in.green_end;
        col_end[2]    = line_in.blue_end;
    end

    // Pixel step: decision update and movement along both axes.
    always_comb
    begin
        steps_next = steps_left_reg - 1'b1;
        last       = steps_next == '0;
        minor_move = minor_used_reg && decision_reg[DEC_BITS-1];
        len_diff   = major_len_reg - minor_len_reg;
        if (minor_move)
            decision_next = decision_reg + $signed({2'b00, len_diff, 1'b0});
        else
            decision_next = decision_reg - $signed({2'b00, minor_len_reg, 1'b0});
        moving = major_len_reg != '0;
        x_next = cur_x_reg;
        y_next = cur_y_reg;
        if (moving)
        begin
            if (major_is_x_reg)
            begin
                x_next = major_step_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                if (minor_move)
                    y_next = minor_step_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
            end
            else
            begin
                y_next = major_step_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                if (minor_move)
                    x_next = minor_step_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
            end
        end
    end

    // Shared divider: |end - start| * 2^F over the major length, one channel at a time.
    always_comb
    begin
        div_req.start    = state_reg == ST_START;
        div_req.dividend = {diff_mag_reg[chan_reg], {COLOR_FRAC_BITS{1'b0}}};
        div_req.divisor  = major_len_reg;
        quo_ext          = {1'b0, div_rsp.quotient};
        inc_signed       = diff_neg_reg[chan_reg] ? $signed(-quo_ext) : $signed(quo_ext);
    end

    mlcr_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer and line state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            active_reg         <= 1'b0;
            chan_reg           <= '0;
            cur_x_reg          <= '0;
            cur_y_reg          <= '0;
            steps_left_reg     <= '0;
            decision_reg       <= '0;
            major_is_x_reg     <= 1'b0;
            minor_used_reg     <= 1'b0;
            major_step_neg_reg <= 1'b0;
            minor_step_neg_reg <= 1'b0;
            major_len_reg      <= '0;
            minor_len_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (do_load)
                    begin
                        active_reg         <= 1'b1;
                        cur_x_reg          <= line_in.x_start;
                        cur_y_reg          <= line_in.y_start;
                        major_is_x_reg     <= load_major_x;
                        major_len_reg      <= load_major;
                        minor_len_reg      <= load_minor;
                        minor_used_reg     <= load_minor != '0;
                        major_step_neg_reg <= load_major_x ? dx[COORD_BITS] : dy[COORD_BITS];
                        minor_step_neg_reg <= load_major_x ? dy[COORD_BITS] : dx[COORD_BITS];
                        decision_reg       <= load_decision;
                        steps_left_reg     <= (load_major == '0) ? COORD_BITS'(1) : load_major;
                        chan_reg           <= '0;
                        if (load_major != '0)
                            state_reg <= ST_START;
                    end
                    else if (do_step)
                    begin
                        steps_left_reg <= steps_next;
                        decision_reg   <= decision_next;
                        cur_x_reg      <= x_next;
                        cur_y_reg      <= y_next;
                        if (last)
                            active_reg <= 1'b0;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        if (chan_reg == CHAN_BITS'(NUM_CHAN - 1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            chan_reg  <= chan_reg + 1'b1;
                            state_reg <= ST_START;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Color accumulators, steps and channel differences.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            if (do_load)
            begin
                color_acc_reg[k] <= {col_start[k], {COLOR_FRAC_BITS{1'b0}}};
                color_inc_reg[k] <= '0;
                diff_neg_reg[k]  <= col_end[k] < col_start[k];
                diff_mag_reg[k]  <= (col_end[k] < col_start[k]) ? col_start[k] - col_end[k]
                                                                : col_end[k] - col_start[k];
            end
            else if (do_step)
            begin
                color_acc_reg[k] <= color_acc_reg[k] + color_inc_reg[k][ACC_BITS-1:0];
            end
        end
        if ((state_reg == ST_WAIT) && div_rsp.done)
            color_inc_reg[chan_reg] <= inc_signed;
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (do_step)
            out_valid_reg <= 1'b1;
        else if (pixel_out.ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            out_x_reg    <= cur_x_reg;
            out_y_reg    <= cur_y_reg;
            out_last_reg <= last;
            for (int k = 0; k < NUM_CHAN; k++)
                out_color_reg[k] <= color_acc_reg[k][ACC_BITS-1:COLOR_FRAC_BITS];
        end
    end

    assign pixel_out.valid      = out_valid_reg;
    assign pixel_out.pixel_x    = out_x_reg;
    assign pixel_out.pixel_y    = out_y_reg;
    assign pixel_out.red        = out_color_reg[0];
    assign pixel_out.green      = out_color_reg[1];
    assign pixel_out.blue       = out_color_reg[2];
    assign pixel_out.last_pixel = out_last_reg;

`ifndef SYNTHESIS
    // An active line always has at least one pixel left.
    a_active_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> steps_left_reg != '0)
        else $error("active line with no pixels left");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_WAIT)
        else $error("divider finished outside of its wait state");

    // Emitting the final pixel ends the line.
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (do_step && last) |=> (!active_reg && out_valid_reg && out_last_reg))
        else $error("line still active after its last pixel");
`endif

endmodule

/* hdl/mlcr_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle, for the color steps.
module mlcr_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  mlcr_pkg::div_req_t req,
    output mlcr_pkg::div_rsp_t rsp
);
    import mlcr_pkg::*;

    logic                    busy_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [COORD_BITS-1:0]   rem_reg;
    logic [ACC_BITS-1:0]     quo_reg;
    logic [COORD_BITS-1:0]   divisor_reg;

    logic [COORD_BITS:0]     shifted;
    logic                    fits;
    logic [COORD_BITS:0]     rem_diff;
    logic [COORD_BITS-1:0]   rem_next;
    logic [ACC_BITS-1:0]     quo_next;
    logic                    stepping;

    // One trial subtraction of the shifted partial remainder.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[ACC_BITS-1]};
        fits     = shifted >= {1'b0, divisor_reg};
        rem_diff = shifted - {1'b0, divisor_reg};
        rem_next = fits ? rem_diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
        quo_next = {quo_reg[ACC_BITS-2:0], fits};
        stepping = busy_reg && (cnt_reg != '0);
    end

    // Sequencing: count the quotient bits down, report completion once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_BITS'(DIV_STEPS);
        end
        else if (stepping)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
        else if (busy_reg)
        begin
            busy_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (stepping)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = busy_reg && (cnt_reg == '0);
    assign rsp.quotient = quo_reg;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the midpoint line color rasterizer top level.
module tb_top;
    import mlcr_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 10;
    localparam int RANDOM_ITEMS    = 1500;
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int COORD_MAX       = (1 << COORD_BITS) - 1;

    // One line request as queued for the driver.
    typedef struct packed {
        logic                  pause_first;
        logic                  mode;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
        logic [COLOR_BITS-1:0] red_start;
        logic [COLOR_BITS-1:0] green_start;
        logic [COLOR_BITS-1:0] blue_start;
        logic [COLOR_BITS-1:0] red_end;
        logic [COLOR_BITS-1:0] green_end;
        logic [COLOR_BITS-1:0] blue_end;
    } line_req_t;

    // One pixel as it should leave the block.
    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic                  last_pixel;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n;

    mlcr_item_if  line_in ();
    mlcr_pixel_if pixel_out ();

    midpoint_line_color_raster u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_in   (line_in),
        .pixel_out (pixel_out)
    );

    // Requests waiting to be driven and pixels waiting to be seen.
    line_req_t req_q[$];
    pixel_t    pixels_due[$];
    int        pred_count;
    int        got_count    = 0;
    int        fail_count   = 0;
    int        load_count   = 0;
    int        idle_steps   = 0;
    int        quiet_cycles = 0;

    // Tracer state: the line being walked, as the block should hold it.
    logic                  tr_active;
    logic [COORD_BITS-1:0] tr_x;
    logic [COORD_BITS-1:0] tr_y;
    int                    tr_left;
    int                    tr_decision;
    logic                  tr_x_major;
    logic                  tr_minor_used;
    logic                  tr_major_neg;
    logic                  tr_minor_neg;
    int                    tr_major_len;
    int                    tr_minor_len;
    longint                tr_acc[NUM_CHAN];
    longint                tr_inc[NUM_CHAN];

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Append a request at the tail of the driver's list.
    function automatic void add_req(line_req_t r);
        req_q.insert(req_q.size(), r);
    endfunction

    function automatic void trace_reset();
        tr_active     = 1'b0;
        tr_x          = '0;
        tr_y          = '0;
        tr_left       = 0;
        tr_decision   = 0;
        tr_x_major    = 1'b0;
        tr_minor_used = 1'b0;
        tr_major_neg  = 1'b0;
        tr_minor_neg  = 1'b0;
        tr_major_len  = 0;
        tr_minor_len  = 0;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            tr_acc[k] = 0;
            tr_inc[k] = 0;
        end
    endfunction

    // Latch a new line: major axis, doubled midpoint decision, color steps.
    function automatic void trace_load(line_req_t rq);
        int     dx;
        int     dy;
        int     adx;
        int     ady;
        longint cs[NUM_CHAN];
        longint ce[NUM_CHAN];
        dx  = int'(rq.x_end) - int'(rq.x_start);
        dy  = int'(rq.y_end) - int'(rq.y_start);
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        tr_x       = rq.x_start;
        tr_y       = rq.y_start;
        tr_x_major = adx >= ady;
        if (tr_x_major)
        begin
            tr_major_len = adx;
            tr_minor_len = ady;
            tr_major_neg = dx < 0;
            tr_minor_neg = dy < 0;
        end
        else
        begin
            tr_major_len = ady;
            tr_minor_len = adx;
            tr_major_neg = dy < 0;
            tr_minor_neg = dx < 0;
        end
        tr_minor_used = tr_minor_len != 0;
        tr_decision   = tr_major_len - 2 * tr_minor_len;
        tr_left       = (tr_major_len == 0) ? 1 : tr_major_len;
        cs[0] = rq.red_start;
        cs[1] = rq.green_start;
        cs[2] = rq.blue_start;
        ce[0] = rq.red_end;
        ce[1] = rq.green_end;
        ce[2] = rq.blue_end;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            tr_acc[k] = cs[k] <<< COLOR_FRAC_BITS;
            if (tr_major_len == 0)
                tr_inc[k] = 0;
            else
                tr_inc[k] = ((ce[k] - cs[k]) * (longint'(1) <<< COLOR_FRAC_BITS))
                            / longint'(tr_major_len);
        end
        tr_active = 1'b1;
    endfunction

    // Emit the current pixel and advance one unit along the major axis.
    function automatic bit trace_step(output pixel_t px);
        logic                  minor_move;
        longint                a;
        logic [COLOR_BITS-1:0] chan[NUM_CHAN];
        px = '0;
        if (!tr_active)
            return 1'b0;
        tr_left = tr_left - 1;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            a       = tr_acc[k] < 0 ? 0 : tr_acc[k];
            chan[k] = COLOR_BITS'(a >>> COLOR_FRAC_BITS);
        end
        px.pixel_x    = tr_x;
        px.pixel_y    = tr_y;
        px.red        = chan[0];
        px.green      = chan[1];
        px.blue       = chan[2];
        px.last_pixel = tr_left == 0;

        minor_move = tr_minor_used && tr_decision < 0;
        if (minor_move)
            tr_decision = tr_decision + 2 * (tr_major_len - tr_minor_len);
        else
            tr_decision = tr_decision - 2 * tr_minor_len;

        if (tr_major_len != 0)
        begin
            if (tr_x_major)
            begin
                tr_x = tr_major_neg ? tr_x - 1'b1 : tr_x + 1'b1;
                if (minor_move)
                    tr_y = tr_minor_neg ? tr_y - 1'b1 : tr_y + 1'b1;
            end
            else
            begin
                tr_y = tr_major_neg ? tr_y - 1'b1 : tr_y + 1'b1;
                if (minor_move)
                    tr_x = tr_minor_neg ? tr_x - 1'b1 : tr_x + 1'b1;
            end
        end
        for (int k = 0; k < NUM_CHAN; k++)
            tr_acc[k] = tr_acc[k] + tr_inc[k];
        if (px.last_pixel)
            tr_active = 1'b0;
        return 1'b1;
    endfunction

    // Idle length for either side: mostly none or short, a few long, and
    // now and then a calm stretch with no idling at all.
    function automatic int pick_gap(ref int calm);
        int r;
        if (calm != 0)
        begin
            calm = calm - 1;
            return 0;
        end
        r = $urandom_range(999);
        if (r < 15)
            calm = $urandom_range(200, 50);
        if (r < 550)
            return 0;
        if (r < 900)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // A request with random content in every field.
    function automatic line_req_t rand_req(logic mode);
        line_req_t r;
        r.pause_first = 1'b0;
        r.mode        = mode;
        r.x_start     = COORD_BITS'($urandom);
        r.y_start     = COORD_BITS'($urandom);
        r.x_end       = COORD_BITS'($urandom);
        r.y_end       = COORD_BITS'($urandom);
        r.red_start   = COLOR_BITS'($urandom);
        r.green_start = COLOR_BITS'($urandom);
        r.blue_start  = COLOR_BITS'($urandom);
        r.red_end     = COLOR_BITS'($urandom);
        r.green_end   = COLOR_BITS'($urandom);
        r.blue_end    = COLOR_BITS'($urandom);
        return r;
    endfunction

    function automatic line_req_t make_load(int xs, int ys, int xe, int ye,
                                            int rs, int gs, int bs,
                                            int re, int ge, int be);
        line_req_t r;
        r = rand_req(MODE_LOAD);
        r.x_start     = COORD_BITS'(xs);
        r.y_start     = COORD_BITS'(ys);
        r.x_end       = COORD_BITS'(xe);
        r.y_end       = COORD_BITS'(ye);
        r.red_start   = COLOR_BITS'(rs);
        r.green_start = COLOR_BITS'(gs);
        r.blue_start  = COLOR_BITS'(bs);
        r.red_end     = COLOR_BITS'(re);
        r.green_end   = COLOR_BITS'(ge);
        r.blue_end    = COLOR_BITS'(be);
        return r;
    endfunction

    // Move a coordinate by delta, mirrored when it would leave the grid.
    function automatic int offset_coord(int base, int delta);
        int e;
        e = base + delta;
        if (e < 0 || e > COORD_MAX)
            e = base - delta;
        return e;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Request driver: holds a request until taken, then idles or sends the next.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        line_req_t cur;
        line_req_t nxt;
        pixel_t    px;
        logic      took;
        int        pred_now;
        int        send_gap;
        int        send_calm;
        if (!rst_n)
        begin
            line_in.valid       <= 1'b0;
            line_in.mode        <= MODE_STEP;
            line_in.x_start     <= '0;
            line_in.y_start     <= '0;
            line_in.x_end       <= '0;
            line_in.y_end       <= '0;
            line_in.red_start   <= '0;
            line_in.green_start <= '0;
            line_in.blue_start  <= '0;
            line_in.red_end     <= '0;
            line_in.green_end   <= '0;
            line_in.blue_end    <= '0;
            pred_count          <= 0;
            send_gap  = 0;
            send_calm = 0;
            trace_reset();
        end
        else
        begin
            took     = line_in.valid && line_in.ready;
            pred_now = pred_count;
            if (took)
            begin
                cur = '{1'b0, line_in.mode, line_in.x_start, line_in.y_start,
                        line_in.x_end, line_in.y_end, line_in.red_start,
                        line_in.green_start, line_in.blue_start, line_in.red_end,
                        line_in.green_end, line_in.blue_end};
                if (cur.mode == MODE_LOAD)
                begin
                    trace_load(cur);
                    load_count++;
                end
                else if (trace_step(px))
                begin
                    pixels_due.insert(pixels_due.size(), px);
                    pred_now++;
                end
                else
                    idle_steps++;
            end

            if (line_in.valid && !took)
            begin
                // Hold the offered request until it is taken.
            end
            else if (send_gap != 0)
            begin
                line_in.valid <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (req_q.size() != 0 && !(req_q[0].pause_first && pred_now != got_count))
            begin
                nxt = req_q.pop_front();
                line_in.valid       <= 1'b1;
                line_in.mode        <= nxt.mode;
                line_in.x_start     <= nxt.x_start;
                line_in.y_start     <= nxt.y_start;
                line_in.x_end       <= nxt.x_end;
                line_in.y_end       <= nxt.y_end;
                line_in.red_start   <= nxt.red_start;
                line_in.green_start <= nxt.green_start;
                line_in.blue_start  <= nxt.blue_start;
                line_in.red_end     <= nxt.red_end;
                line_in.green_end   <= nxt.green_end;
                line_in.blue_end    <= nxt.blue_end;
                send_gap = pick_gap(send_calm);
            end
            else
                line_in.valid <= 1'b0;
            pred_count <= pred_now;
        end
    end

    // Pixel receiver: random stalls plus one long hold-off while requests pile up.
    always @(posedge clk or negedge rst_n)
    begin : pixel_sink
        int   hold;
        int   sink_calm;
        logic hold_off_done;
        if (!rst_n)
        begin
            pixel_out.ready <= 1'b0;
            hold          = 0;
            sink_calm     = 0;
            hold_off_done = 1'b0;
        end
        else
        begin
            if (!hold_off_done && got_count >= HOLD_OFF_AT)
            begin
                hold_off_done = 1'b1;
                hold          = HOLD_OFF_CYCLES;
            end
            if (hold != 0)
            begin
                pixel_out.ready <= 1'b0;
                hold = hold - 1;
            end
            else
            begin
                pixel_out.ready <= 1'b1;
                hold = pick_gap(sink_calm);
            end
        end
    end

    // Pixel checker: compares each accepted pixel with the oldest expectation.
    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n && pixel_out.valid && pixel_out.ready)
        begin
            if (pixels_due.size() == 0)
            begin
                $error("pixel (%0d, %0d) arrived with none expected",
                       pixel_out.pixel_x, pixel_out.pixel_y);
                fail_count++;
            end
            else
            begin
                want = pixels_due.pop_front();
                check_field("pixel_x", want.pixel_x, pixel_out.pixel_x);
                check_field("pixel_y", want.pixel_y, pixel_out.pixel_y);
                check_field("red", want.red, pixel_out.red);
                check_field("green", want.green, pixel_out.green);
                check_field("blue", want.blue, pixel_out.blue);
                check_field("last_pixel", want.last_pixel, pixel_out.last_pixel);
                got_count <= got_count + 1;
            end
        end
    end

    // Watchdog: too long without any transfer on either side ends the run.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (line_in.valid && line_in.ready) ||
            (pixel_out.valid && pixel_out.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Build the request list, release reset and wait for the run to drain.
    initial
    begin : stimulus
        int        planned;
        int        pick;
        int        major;
        int        minor;
        int        npix;
        int        nsteps;
        int        xs;
        int        ys;
        int        dmaj;
        int        dmin;
        logic      pause_next;
        logic      mid_pause_done;
        line_req_t r;

        rst_n = 1'b0;

        // Step before any line is loaded gives nothing.
        add_req(rand_req(MODE_STEP));
        // Point line: one pixel in the start color, then nothing more.
        add_req(make_load(100, 200, 100, 200, 12, 34, 56, 200, 0, 255));
        add_req(rand_req(MODE_STEP));
        add_req(rand_req(MODE_STEP));
        // Short x-major line at the right edge, full color sweeps both ways.
        add_req(make_load(4090, 0, 4095, 0, 0, 255, 0, 255, 0, 0));
        repeat (5) add_req(rand_req(MODE_STEP));
        // Steep y-major line walking toward the origin in both axes.
        add_req(make_load(4095, 4095, 4092, 4088, 255, 0, 128, 0, 255, 127));
        repeat (7) add_req(rand_req(MODE_STEP));
        // Full-span diagonal, cut short by a new load while still active.
        add_req(make_load(0, 0, 4095, 4095, 255, 255, 255, 0, 0, 0));
        repeat (3) add_req(rand_req(MODE_STEP));
        add_req(make_load(0, 4095, 4095, 0, 0, 0, 0, 255, 255, 255));
        repeat (2) add_req(rand_req(MODE_STEP));

        // Random part: mostly complete short lines, some cut short, some noise.
        planned        = 0;
        pause_next     = 1'b1;
        mid_pause_done = 1'b0;
        while (planned < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 88)
            begin
                if ($urandom_range(99) < 3)
                begin
                    // Long line with random endpoints; only its start is walked.
                    r = rand_req(MODE_LOAD);
                    major = 0;
                    npix   = 1;
                    nsteps = $urandom_range(8, 1);
                end
                else
                begin
                    major = ($urandom_range(99) < 20) ? $urandom_range(80, 17)
                                                      : $urandom_range(16, 0);
                    minor = $urandom_range(major, 0);
                    dmaj  = $urandom_range(1) ? -major : major;
                    dmin  = $urandom_range(1) ? -minor : minor;
                    xs    = $urandom_range(COORD_MAX);
                    ys    = $urandom_range(COORD_MAX);
                    r     = rand_req(MODE_LOAD);
                    r.x_start = COORD_BITS'(xs);
                    r.y_start = COORD_BITS'(ys);
                    if ($urandom_range(1))
                    begin
                        r.x_end = COORD_BITS'(offset_coord(xs, dmaj));
                        r.y_end = COORD_BITS'(offset_coord(ys, dmin));
                    end
                    else
                    begin
                        r.x_end = COORD_BITS'(offset_coord(xs, dmin));
                        r.y_end = COORD_BITS'(offset_coord(ys, dmaj));
                    end
                    npix = (major == 0) ? 1 : major;
                    if (pick < 74)
                        nsteps = npix + $urandom_range(2, 0);
                    else
                        nsteps = $urandom_range(npix - 1, 0);
                end
                r.pause_first = pause_next;
                pause_next    = 1'b0;
                add_req(r);
                planned++;
                for (int i = 0; i < nsteps; i++)
                begin
                    add_req(rand_req(MODE_STEP));
                    if (i < npix)
                        planned++;
                end
            end
            else
            begin
                // Noise: a few steps that may or may not find a line.
                repeat ($urandom_range(3, 1))
                begin
                    r = rand_req(MODE_STEP);
                    r.pause_first = pause_next;
                    pause_next    = 1'b0;
                    add_req(r);
                end
            end
            if (!mid_pause_done && planned >= RANDOM_ITEMS / 2)
            begin
                mid_pause_done = 1'b1;
                pause_next     = 1'b1;
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        wait (req_q.size() == 0 && !line_in.valid);
        while (got_count != pred_count)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pixels_due.size() != 0)
            $error("%0d expected pixels never arrived", pixels_due.size());
        $display("Run covered %0d line loads and %0d checked pixels, %0d steps with no line,",
                 load_count, got_count, idle_steps);
        $display("with a %0d-cycle receiver hold-off and sender pauses for a full drain.",
                 HOLD_OFF_CYCLES);
        if (fail_count == 0 && pixels_due.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
